// File: hdl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg
// Shared constants, codes and control/status bundles of the schedule table.
// ----------------------------------------------------------------------------
package tcst_pkg;

	localparam int MAX_ENTRIES  = 8;
	localparam int MAX_TIMES    = 4;
	localparam int RESULT_LIMIT = 8;

	localparam int EIDX_W = $clog2(MAX_ENTRIES);
	localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int TIDX_W = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
	localparam int TCNT_W = $clog2(MAX_TIMES + 1);
	localparam int NCNT_W = $clog2(RESULT_LIMIT + 1);
	localparam int MIN_W  = 27;
	localparam int DIV_W  = 32;
	localparam int DSR_W  = 11;

	localparam logic [2:0] MODE_BEGIN  = 3'd0;
	localparam logic [2:0] MODE_APPEND = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_CLEAR  = 3'd3;
	localparam logic [2:0] MODE_SETTM  = 3'd4;
	localparam logic [2:0] MODE_CHECK  = 3'd5;
	localparam logic [2:0] MODE_MARK   = 3'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_PENDING   = 3'd3;
	localparam logic [2:0] ST_NONE      = 3'd4;

	localparam logic [1:0] DSEL_STAMP = 2'd0;
	localparam logic [1:0] DSEL_DAY   = 2'd1;
	localparam logic [1:0] DSEL_HOUR  = 2'd2;

	localparam logic [DSR_W-1:0] SEC_PER_MIN = 11'd60;
	localparam logic [DSR_W-1:0] MIN_PER_DAY = 11'd1440;
	localparam logic [31:0]      DAY_BIAS    = 32'd2880;

	// reciprocals: ceil(2^34 / 15) and ceil(2^28 / 45)
	localparam logic [30:0] RCP_15    = 31'd1145324613;
	localparam int          RCP_15_SH = 34;
	localparam logic [22:0] RCP_45    = 23'd5965233;
	localparam int          RCP_45_SH = 28;

	typedef struct packed {
		logic       ld_in;
		logic       idx_clr;
		logic       idx_inc;
		logic       idx_from_f;
		logic       found_set;
		logic       div_start;
		logic [1:0] div_sel;
		logic       wr_time;
		logic       wr_day;
		logic       wr_hhmm;
		logic       do_begin;
		logic       do_append;
		logic       do_mark;
		logic       do_clear;
		logic       do_shift;
		logic       cnt_dec;
		logic       hold;
		logic       emit;
		logic [2:0] emit_status;
		logic       emit_last;
		logic       emit_held;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       at_end;
		logic       hit;
		logic       found;
		logic       tbl_full;
		logic       list_full;
		logic       shift_end;
		logic       due;
		logic       at_limit;
		logic       n_zero;
		logic       time_unset;
		logic       div_done;
		logic       out_free;
	} sts_t;

endpackage

// File: hdl/tcst_div.sv
// ----------------------------------------------------------------------------
// tcst_div
// Divide by 60 or by 1440 through reciprocal multiplication.
// ----------------------------------------------------------------------------
module tcst_div
	import tcst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       sel,
	input  logic [DIV_W-1:0] dividend,
	output logic             done,
	output logic [DIV_W-1:0] quot,
	output logic [DSR_W-1:0] rem
);

	logic             v1_q;
	logic             v2_q;
	logic             done_q;
	logic             by_day_q;
	logic [DIV_W-1:0] x_q;
	logic [DIV_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [29:0]      mul_a;
	logic [30:0]      mul_b;
	logic [60:0]      mul_p;
	logic [DIV_W-1:0] quo_d;
	logic [DIV_W-1:0] back;

	// x/60 = (x>>2)/15, x/1440 = (x>>5)/45
	always_comb begin
		if (by_day_q) begin
			mul_a = 30'(x_q[DIV_W-1:5]);
			mul_b = 31'(RCP_45);
		end else begin
			mul_a = x_q[DIV_W-1:2];
			mul_b = RCP_15;
		end
		mul_p = mul_a * mul_b;
		quo_d = by_day_q ? 32'(mul_p[60:RCP_45_SH]) : 32'(mul_p[60:RCP_15_SH]);
	end

	assign back = by_day_q ? quo_q * 32'(MIN_PER_DAY) : quo_q * 32'(SEC_PER_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v1_q   <= start;
			v2_q   <= v1_q;
			done_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q      <= dividend;
			by_day_q <= (sel == DSEL_DAY);
		end
		if (v1_q)
			quo_q <= quo_d;
		if (v2_q)
			rem_q <= DSR_W'(x_q - back);
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// File: hdl/tcst_dp.sv
// ----------------------------------------------------------------------------
// tcst_dp
// Datapath: table storage, walk index, time base and the result register.
// ----------------------------------------------------------------------------
module tcst_dp
	import tcst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [2:0]         mode,
	input  logic [7:0]         command,
	input  logic [11:0]        time_of_day,
	input  logic [31:0]        timestamp,
	input  logic [3:0]         max_pending,
	input  logic               cfg_we,
	input  logic signed [10:0] cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [7:0]         pending_command,
	output logic               last
);

	logic [7:0]        code_q [MAX_ENTRIES];
	logic [TCNT_W-1:0] tcnt_q [MAX_ENTRIES];
	logic [11:0]       times_q [MAX_ENTRIES][MAX_TIMES];
	logic [MIN_W-1:0]  lrun_q [MAX_ENTRIES];

	logic [ECNT_W-1:0] count_q;
	logic [ECNT_W-1:0] i_q;
	logic [EIDX_W-1:0] f_q;
	logic              found_q;
	logic [NCNT_W-1:0] n_q;
	logic [NCNT_W-1:0] lim_q;
	logic [2:0]        mode_q;
	logic [7:0]        code_in_q;
	logic [11:0]       tod_q;
	logic [31:0]       stamp_q;
	logic [MIN_W-1:0]  cur_min_q;
	logic              unset_q;
	logic signed [10:0] zone_q;
	logic [10:0]       day_min_q;
	logic [11:0]       hhmm_q;
	logic [7:0]        held_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        pcmd_q;
	logic              last_q;

	logic [EIDX_W-1:0] ix;
	logic [ECNT_W-1:0] ip1;
	logic [EIDX_W-1:0] ixn;
	logic [EIDX_W-1:0] cx;
	logic              match;
	logic [DIV_W-1:0]  dvd;
	logic              dv_done;
	logic [DIV_W-1:0]  dv_q;
	logic [DSR_W-1:0]  dv_r;
	logic [11:0]       hh100;

	assign ix  = i_q[EIDX_W-1:0];
	assign ip1 = i_q + 1'b1;
	assign ixn = ip1[EIDX_W-1:0];
	assign cx  = count_q[EIDX_W-1:0];

	always_comb begin
		match = 1'b0;
		for (int j = 0; j < MAX_TIMES; j++)
			if (TCNT_W'(j) < tcnt_q[ix] && times_q[ix][j] == hhmm_q)
				match = 1'b1;
	end

	always_comb begin
		case (cmd.div_sel)
			DSEL_STAMP: dvd = stamp_q;
			DSEL_DAY:   dvd = 32'(cur_min_q) + 32'(signed'(zone_q)) + DAY_BIAS;
			DSEL_HOUR:  dvd = 32'(day_min_q);
			default:    dvd = '0;
		endcase
	end

	tcst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.sel      (cmd.div_sel),
		.dividend (dvd),
		.done     (dv_done),
		.quot     (dv_q),
		.rem      (dv_r)
	);

	assign hh100 = 12'(dv_q[4:0]) * 12'd100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			unset_q     <= 1'b1;
			cur_min_q   <= '0;
			zone_q      <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_we)
				zone_q <= cfg_wdata;
			if (cmd.wr_time) begin
				unset_q   <= (stamp_q == '0);
				cur_min_q <= dv_q[MIN_W-1:0];
			end
			if (cmd.idx_clr)
				found_q <= 1'b0;
			else if (cmd.found_set)
				found_q <= 1'b1;
			if (cmd.do_clear)
				count_q <= '0;
			else if (cmd.do_begin && !found_q)
				count_q <= count_q + 1'b1;
			else if (cmd.cnt_dec)
				count_q <= count_q - 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			mode_q    <= mode;
			code_in_q <= command;
			tod_q     <= time_of_day;
			stamp_q   <= timestamp;
			lim_q     <= (max_pending > 4'(RESULT_LIMIT)) ?
				NCNT_W'(RESULT_LIMIT) : NCNT_W'(max_pending);
		end
		if (cmd.idx_clr) begin
			i_q <= '0;
			n_q <= '0;
		end else if (cmd.idx_from_f)
			i_q <= ECNT_W'(f_q);
		else if (cmd.idx_inc)
			i_q <= ip1;
		if (cmd.hold)
			n_q <= n_q + 1'b1;
		if (cmd.found_set)
			f_q <= ix;
		if (cmd.wr_day)
			day_min_q <= dv_r;
		if (cmd.wr_hhmm)
			hhmm_q <= hh100 + 12'(dv_r);
		if (cmd.hold)
			held_q <= code_q[ix];
		if (cmd.do_begin) begin
			if (found_q) begin
				tcnt_q[f_q] <= '0;
				lrun_q[f_q] <= '0;
			end else begin
				code_q[cx] <= code_in_q;
				tcnt_q[cx] <= '0;
				lrun_q[cx] <= '0;
			end
		end
		if (cmd.do_append) begin
			times_q[f_q][tcnt_q[f_q][TIDX_W-1:0]] <= tod_q;
			tcnt_q[f_q] <= tcnt_q[f_q] + 1'b1;
		end
		if (cmd.do_mark)
			lrun_q[f_q] <= cur_min_q;
		if (cmd.do_shift) begin
			code_q[ix]  <= code_q[ixn];
			tcnt_q[ix]  <= tcnt_q[ixn];
			times_q[ix] <= times_q[ixn];
			lrun_q[ix]  <= lrun_q[ixn];
		end
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			pcmd_q   <= cmd.emit_held ? held_q : 8'd0;
			last_q   <= cmd.emit_last;
		end
	end

	assign sts.mode       = mode_q;
	assign sts.at_end     = i_q >= count_q;
	assign sts.hit        = code_q[ix] == code_in_q;
	assign sts.found      = found_q;
	assign sts.tbl_full   = count_q >= ECNT_W'(MAX_ENTRIES);
	assign sts.list_full  = tcnt_q[f_q] >= TCNT_W'(MAX_TIMES);
	assign sts.shift_end  = ip1 >= count_q;
	assign sts.due        = match && (cur_min_q != lrun_q[ix]);
	assign sts.at_limit   = n_q >= lim_q;
	assign sts.n_zero     = n_q == '0;
	assign sts.time_unset = unset_q;
	assign sts.div_done   = dv_done;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign pending_command = pcmd_q;
	assign last            = last_q;

endmodule

// File: hdl/tcst_ctrl.sv
// ----------------------------------------------------------------------------
// tcst_ctrl
// Sequencer: lookup walk, mode execution, time conversion and check walk.
// ----------------------------------------------------------------------------
module tcst_ctrl
	import tcst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DIVT  = 3'd4;
	localparam logic [2:0] S_DIVD  = 3'd5;
	localparam logic [2:0] S_DIVH  = 3'd6;
	localparam logic [2:0] S_WALK  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       tdone_q;
	logic       tdone_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tdone_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tdone_q <= tdone_d;
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.emit_last   = 1'b1;
		cmd.emit_status = ST_OK;
		state_d         = state_q;
		tdone_d         = tdone_q;
		in_ready        = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in   = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.at_end)
					state_d = S_EXEC;
				else if (sts.hit) begin
					cmd.found_set = 1'b1;
					state_d       = S_EXEC;
				end else
					cmd.idx_inc = 1'b1;
			end
			S_EXEC: begin
				case (sts.mode)
					MODE_SETTM: begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DSEL_STAMP;
						tdone_d       = 1'b0;
						state_d       = S_DIVT;
					end
					MODE_CHECK: begin
						if (sts.time_unset) begin
							if (sts.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_NONE;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DSEL_DAY;
							state_d       = S_DIVD;
						end
					end
					MODE_REMOVE: begin
						if (!sts.found) begin
							if (sts.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_NOT_FOUND;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.idx_from_f = 1'b1;
							state_d        = S_SHIFT;
						end
					end
					default: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
							case (sts.mode)
								MODE_BEGIN: begin
									if (!sts.found && sts.tbl_full)
										cmd.emit_status = ST_FULL;
									else
										cmd.do_begin = 1'b1;
								end
								MODE_APPEND: begin
									if (!sts.found)
										cmd.emit_status = ST_NOT_FOUND;
									else if (sts.list_full)
										cmd.emit_status = ST_FULL;
									else
										cmd.do_append = 1'b1;
								end
								MODE_MARK: begin
									if (!sts.found)
										cmd.emit_status = ST_NOT_FOUND;
									else
										cmd.do_mark = 1'b1;
								end
								MODE_CLEAR: cmd.do_clear = 1'b1;
								default: ;
							endcase
						end
					end
				endcase
			end
			S_SHIFT: begin
				if (sts.shift_end) begin
					if (sts.out_free) begin
						cmd.cnt_dec = 1'b1;
						cmd.emit    = 1'b1;
						state_d     = S_IDLE;
					end
				end else begin
					cmd.do_shift = 1'b1;
					cmd.idx_inc  = 1'b1;
				end
			end
			S_DIVT: begin
				cmd.div_sel = DSEL_STAMP;
				if (sts.div_done) begin
					cmd.wr_time = 1'b1;
					tdone_d     = 1'b1;
				end
				if (tdone_q && sts.out_free) begin
					cmd.emit = 1'b1;
					tdone_d  = 1'b0;
					state_d  = S_IDLE;
				end
			end
			S_DIVD: begin
				cmd.div_sel = DSEL_DAY;
				if (sts.div_done) begin
					cmd.wr_day = 1'b1;
					state_d    = S_DIVH;
				end
			end
			S_DIVH: begin
				cmd.div_sel = DSEL_HOUR;
				if (!tdone_q) begin
					cmd.div_start = 1'b1;
					tdone_d       = 1'b1;
				end else if (sts.div_done) begin
					cmd.wr_hhmm = 1'b1;
					cmd.idx_clr = 1'b1;
					tdone_d     = 1'b0;
					state_d     = S_WALK;
				end
			end
			S_WALK: begin
				cmd.emit_held = 1'b1;
				if (sts.at_end || sts.at_limit) begin
					if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = sts.n_zero ? ST_NONE : ST_PENDING;
						cmd.emit_held   = !sts.n_zero;
						state_d         = S_IDLE;
					end
				end else if (sts.due) begin
					if (sts.n_zero) begin
						cmd.hold    = 1'b1;
						cmd.idx_inc = 1'b1;
					end else if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = ST_PENDING;
						cmd.emit_last   = 1'b0;
						cmd.hold        = 1'b1;
						cmd.idx_inc     = 1'b1;
					end
				end else
					cmd.idx_inc = 1'b1;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: hdl/timed_command_schedule_table_core.sv
// ----------------------------------------------------------------------------
// timed_command_schedule_table_core
// Table of scheduled commands with time lists, last-run stamps and due check.
// ----------------------------------------------------------------------------
// One item at a time. Every item first walks the table for its command code,
// one entry per cycle. Begin, append, mark, clear and unused modes then
// finish once the output is free; remove moves each later entry up, one per
// cycle. Set time converts seconds to minutes with a reciprocal divide. A
// check runs two such divides to get local hour and minute, then tests one
// entry per cycle against all its times, holding on an entry while a result
// waits for the output.
module timed_command_schedule_table_core
	import tcst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [7:0]         command,
	input  logic [11:0]        time_of_day,
	input  logic [31:0]        timestamp,
	input  logic [3:0]         max_pending,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [7:0]         pending_command,
	output logic               last,
	input  logic               cfg_we,
	input  logic signed [10:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	tcst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcst_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.command         (command),
		.time_of_day     (time_of_day),
		.timestamp       (timestamp),
		.max_pending     (max_pending),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.pending_command (pending_command),
		.last            (last)
	);

endmodule
